### src/mclp_pkg.sv
package mclp_pkg;

    // Line buffer capacity in bytes (9..128); the last slot is never filled
    localparam int LINE_CAPACITY = 64;
    localparam int POS_W         = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

    // Keyword prefixes
    localparam int KW_COUNT  = 6;
    localparam int KW_MAXLEN = 8;
    localparam logic [POS_W-1:0] NUM_START = POS_W'(6);

    // Accumulator saturates at all ones
    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Reset values
    localparam logic [15:0] MAX_DUTY_RST = 16'd8999;
    localparam logic [15:0] DUTY_RST     = 16'd4500;
    localparam logic [3:0]  DIR_RST      = 4'd5;

    // Byte codes
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CMD_FORWARD  = 3'd0,
        CMD_BACKWARD = 3'd1,
        CMD_LEFT     = 3'd2,
        CMD_RIGHT    = 3'd3,
        CMD_STOP     = 3'd4,
        CMD_SPEED    = 3'd5,
        CMD_UNKNOWN  = 3'd6
    } t_cmd;

    // Number parser phase, one-hot
    typedef enum logic [2:0] {
        NUM_BLANK = 3'b001,
        NUM_DIGIT = 3'b010,
        NUM_DONE  = 3'b100
    } t_num_phase;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  dir;
        logic [15:0] duty;
    } t_result;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{8'h46, 8'h4F, 8'h52, 8'h57, 8'h41, 8'h52, 8'h44, 8'h00},  // FORWARD
        '{8'h42, 8'h41, 8'h43, 8'h4B, 8'h57, 8'h41, 8'h52, 8'h44},  // BACKWARD
        '{8'h4C, 8'h45, 8'h46, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},  // LEFT
        '{8'h52, 8'h49, 8'h47, 8'h48, 8'h54, 8'h00, 8'h00, 8'h00},  // RIGHT
        '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},  // STOP
        '{8'h53, 8'h50, 8'h45, 8'h45, 8'h44, 8'h20, 8'h00, 8'h00}   // "SPEED "
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        POS_W'(7), POS_W'(8), POS_W'(4), POS_W'(5), POS_W'(4), POS_W'(6)
    };

    localparam t_cmd KW_CMD [KW_COUNT] = '{
        CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_SPEED
    };

    // Wheel direction bits for the four motion commands
    localparam logic [3:0] KW_DIR [4] = '{4'd5, 4'd10, 4'd6, 4'd9};

endpackage

### src/mclp_in_stage.sv
module mclp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_data;

    // Slot frees when the parser takes the byte this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    a_take_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_valid)
        else $error("in stage: take without a held byte");

endmodule

### src/mclp_parse.sv
module mclp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data,
    output logic                o_take,
    input  logic                i_out_free,
    output logic                o_res_valid,
    output mclp_pkg::t_result   o_res,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data
);

    logic [mclp_pkg::POS_W-1:0]       r_pos,   n_pos;
    logic [mclp_pkg::KW_COUNT-1:0]    r_alive, n_alive;
    mclp_pkg::t_num_phase             r_phase, n_phase;
    logic                             r_neg,   n_neg;
    logic [mclp_pkg::ACC_W-1:0]       r_val,   n_val;
    logic [3:0]                       r_dir,   n_dir;
    logic [15:0]                      r_duty,  n_duty;
    logic [15:0]                      r_max_duty;

    logic                             is_term;
    logic                             is_blank;
    logic                             is_digit;
    logic                             has_result;
    logic                             feed_digit;
    logic [mclp_pkg::ACC_W+3:0]       mac;
    logic [mclp_pkg::ACC_W-1:0]       spd;
    mclp_pkg::t_cmd                   cmd;

    // Byte classes
    assign is_term  = (i_data == mclp_pkg::CH_LF) || (i_data == mclp_pkg::CH_CR);
    assign is_blank = (i_data == mclp_pkg::CH_SPACE) || (i_data == mclp_pkg::CH_TAB) ||
                      (i_data == mclp_pkg::CH_VT) || (i_data == mclp_pkg::CH_FF);
    assign is_digit = (i_data >= mclp_pkg::CH_ZERO) && (i_data <= mclp_pkg::CH_NINE);

    // Non-empty line end produces a result; stall only if the output is full
    assign has_result  = is_term && (r_pos != '0);
    assign o_take      = i_valid && (!has_result || i_out_free);
    assign o_res_valid = o_take && has_result;

    // value * 10 + digit, saturated
    assign mac = ({4'b0, r_val} << 3) + ({4'b0, r_val} << 1) +
                 {{(mclp_pkg::ACC_W){1'b0}}, i_data[3:0]};

    // Highest priority surviving full-length prefix
    always_comb begin
        cmd = mclp_pkg::CMD_UNKNOWN;
        for (int k = mclp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (r_alive[k] && (r_pos >= mclp_pkg::KW_LEN[k])) begin
                cmd = mclp_pkg::KW_CMD[k];
            end
        end
    end

    // Clamped speed request
    assign spd = r_neg ? '0 : r_val;

    // Next state
    always_comb begin
        n_pos      = r_pos;
        n_alive    = r_alive;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_val      = r_val;
        n_dir      = r_dir;
        n_duty     = r_duty;
        feed_digit = 1'b0;

        if (is_term) begin
            // Apply the command, then start a fresh line
            if (has_result) begin
                case (cmd)
                    mclp_pkg::CMD_FORWARD,
                    mclp_pkg::CMD_BACKWARD,
                    mclp_pkg::CMD_LEFT,
                    mclp_pkg::CMD_RIGHT: begin
                        n_dir = mclp_pkg::KW_DIR[cmd[1:0]];
                    end
                    mclp_pkg::CMD_STOP: begin
                        n_duty = '0;
                    end
                    mclp_pkg::CMD_SPEED: begin
                        n_duty = ({1'b0, r_max_duty} < spd) ? r_max_duty : spd[15:0];
                    end
                    default: begin
                    end
                endcase
            end
            n_pos   = '0;
            n_alive = '1;
            n_phase = mclp_pkg::NUM_BLANK;
            n_neg   = 1'b0;
            n_val   = '0;
        end else if (r_pos < mclp_pkg::POS_LAST) begin
            // Prefix compare for this position
            for (int k = 0; k < mclp_pkg::KW_COUNT; k++) begin
                if ((r_pos < mclp_pkg::KW_LEN[k]) &&
                    (i_data != mclp_pkg::KW_TEXT[k][r_pos[2:0]])) begin
                    n_alive[k] = 1'b0;
                end
            end
            // Number text after the SPEED prefix
            if (r_pos >= mclp_pkg::NUM_START) begin
                case (r_phase)
                    mclp_pkg::NUM_BLANK: begin
                        if (!is_blank) begin
                            n_phase = mclp_pkg::NUM_DIGIT;
                            if (i_data == mclp_pkg::CH_MINUS) begin
                                n_neg = 1'b1;
                            end else if (i_data != mclp_pkg::CH_PLUS) begin
                                feed_digit = 1'b1;
                            end
                        end
                    end
                    mclp_pkg::NUM_DIGIT: begin
                        feed_digit = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (feed_digit) begin
                    if (is_digit) begin
                        n_val = (mac > {4'b0, mclp_pkg::ACC_MAX}) ? mclp_pkg::ACC_MAX
                                                                  : mac[mclp_pkg::ACC_W-1:0];
                    end else begin
                        n_phase = mclp_pkg::NUM_DONE;
                    end
                end
            end
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_res.cmd  = cmd;
    assign o_res.dir  = n_dir;
    assign o_res.duty = n_duty;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_alive <= '1;
            r_phase <= mclp_pkg::NUM_BLANK;
            r_neg   <= 1'b0;
            r_val   <= '0;
            r_dir   <= mclp_pkg::DIR_RST;
            r_duty  <= mclp_pkg::DUTY_RST;
        end else if (o_take) begin
            r_pos   <= n_pos;
            r_alive <= n_alive;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_val   <= n_val;
            r_dir   <= n_dir;
            r_duty  <= n_duty;
        end
    end

    // Duty clamp register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= mclp_pkg::MAX_DUTY_RST;
        end else if (i_cfg_valid) begin
            r_max_duty <= i_cfg_data;
        end
    end

    a_term_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && is_term) |=> (r_pos == '0) && (r_alive == '1))
        else $error("parse: line state not cleared after terminator");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mclp_pkg::POS_LAST)
        else $error("parse: line position past capacity");

    a_stop_zeroes_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (cmd == mclp_pkg::CMD_STOP)) |=> (r_duty == '0))
        else $error("parse: STOP did not zero duty");

endmodule

### src/mclp_out_stage.sv
module mclp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mclp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output mclp_pkg::t_result o_res
);

    logic              r_valid;
    mclp_pkg::t_result r_res;

    // Register can load when empty or draining this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("out stage: load while full");

endmodule

### src/motor_command_line_parser_unit.sv
// Result path: a line terminator goes through the input register, then the result register,
//   before its result shows at o_out_*.
// Throughput: one byte per cycle; the single-pass parse stalls only while the result
//   register holds a result not yet taken.
// Reset (synchronous, active low): empty line, direction 5, duty 4500, max_duty 8999.
module motor_command_line_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_command,
    output logic [3:0]  o_direction_bits,
    output logic [15:0] o_duty,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              take;
    logic              out_free;
    logic              res_valid;
    mclp_pkg::t_result res;
    mclp_pkg::t_result out_res;

    // Configuration write is always taken
    assign o_cfg_ready = 1'b1;

    mclp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_rx_data),
        .o_valid (byte_valid),
        .o_data  (byte_data),
        .i_take  (take)
    );

    mclp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .i_data      (byte_data),
        .o_take      (take),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );

    mclp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_command        = out_res.cmd;
    assign o_direction_bits = out_res.dir;
    assign o_duty           = out_res.duty;

endmodule
